FILE: src/sha1_pkg.sv
package sha1_pkg;

  // Initial chaining values.
  localparam logic [31:0] H_INIT [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  // Round constants, one for each group of twenty rounds.
  localparam logic [31:0] K_0 = 32'h5A827999;
  localparam logic [31:0] K_1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_2 = 32'h8F1BBCDC;
  localparam logic [31:0] K_3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_MARK = 8'h80;

  localparam logic [6:0] ROUND_LAST  = 7'd79;
  localparam logic [6:0] ROUND_GRP_1 = 7'd20;
  localparam logic [6:0] ROUND_GRP_2 = 7'd40;
  localparam logic [6:0] ROUND_GRP_3 = 7'd60;
  localparam logic [5:0] FILL_LAST   = 6'd63;
  localparam logic [5:0] FILL_LEN    = 6'd56;
  localparam logic [2:0] WORD_LAST   = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD_ONE,
    ST_PAD_ZERO,
    ST_PAD_LEN,
    ST_ROUND,
    ST_UPDATE,
    ST_OUTPUT
  } state_t;

  typedef enum logic [1:0] {
    SEL_MSG,
    SEL_MARK,
    SEL_ZERO,
    SEL_LEN
  } byte_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      shift;
    byte_sel_t byte_sel;
    logic      count_len;
    logic      round;
    logic      update;
    logic      out_step;
    logic      clear;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic fill_full;
    logic fill_at_len;
    logic round_done;
    logic word_last;
  } status_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] s);
    logic [63:0] dbl;
    dbl = {v, v} << s;
    return dbl[63:32];
  endfunction

endpackage

FILE: src/sha1_hash_top.sv
// SHA-1 engine taking one message byte per item. An item is accepted when
// start is high and busy is low; an item with has_byte low carries no byte,
// and end_of_message closes the message. Every 64th byte starts a
// compression (80 rounds on one shared round unit, then the chaining update)
// during which busy is high. Closing a message pads the block byte by byte,
// runs one or two compressions and then shows the five digest words on
// consecutive cycles, each marked by done for exactly one cycle; the receiver
// cannot stall them. After the last word the engine is ready for a new message.
module sha1_hash_top
  import sha1_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  msg_byte,
  input  logic        has_byte,
  input  logic        end_of_message,
  output logic        done,
  output logic [31:0] digest_word,
  output logic [2:0]  word_number,
  output logic        last_word
);

  cmd_t    cmd;
  status_t status;

  sha1_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .has_byte       (has_byte),
    .end_of_message (end_of_message),
    .status         (status),
    .cmd            (cmd),
    .busy           (busy),
    .done           (done)
  );

  sha1_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .msg_byte    (msg_byte),
    .status      (status),
    .digest_word (digest_word),
    .word_number (word_number),
    .last_word   (last_word)
  );

endmodule

FILE: src/sha1_ctrl.sv
module sha1_ctrl
  import sha1_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  logic    has_byte,
  input  logic    end_of_message,
  input  status_t status,
  output cmd_t    cmd,
  output logic    busy,
  output logic    done
);

  state_t state, state_next;
  state_t resume, resume_next;

  // State and resume registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      resume <= ST_IDLE;
    end else begin
      state  <= state_next;
      resume <= resume_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next  = state;
    resume_next = resume;
    cmd         = '0;
    cmd.byte_sel = SEL_MSG;
    busy        = 1'b1;
    done        = 1'b0;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (has_byte) begin
            cmd.shift     = 1'b1;
            cmd.count_len = 1'b1;
            if (status.fill_full) begin
              state_next  = ST_ROUND;
              resume_next = end_of_message ? ST_PAD_ONE : ST_IDLE;
            end else if (end_of_message) begin
              state_next = ST_PAD_ONE;
            end
          end else if (end_of_message) begin
            state_next = ST_PAD_ONE;
          end
        end
      end
      ST_PAD_ONE: begin
        cmd.shift    = 1'b1;
        cmd.byte_sel = SEL_MARK;
        if (status.fill_full) begin
          state_next  = ST_ROUND;
          resume_next = ST_PAD_ZERO;
        end else begin
          state_next = ST_PAD_ZERO;
        end
      end
      ST_PAD_ZERO: begin
        if (status.fill_at_len) begin
          state_next = ST_PAD_LEN;
        end else begin
          cmd.shift    = 1'b1;
          cmd.byte_sel = SEL_ZERO;
          if (status.fill_full) begin
            state_next  = ST_ROUND;
            resume_next = ST_PAD_ZERO;
          end
        end
      end
      ST_PAD_LEN: begin
        cmd.shift    = 1'b1;
        cmd.byte_sel = SEL_LEN;
        if (status.fill_full) begin
          state_next  = ST_ROUND;
          resume_next = ST_OUTPUT;
        end
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
        if (status.round_done) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = resume;
      end
      ST_OUTPUT: begin
        done = 1'b1;
        if (status.word_last) begin
          cmd.clear   = 1'b1;
          state_next  = ST_IDLE;
          resume_next = ST_IDLE;
        end else begin
          cmd.out_step = 1'b1;
        end
      end
      default: begin
        state_next  = ST_IDLE;
        resume_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: src/sha1_dpath.sv
module sha1_dpath
  import sha1_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  input  logic [7:0]  msg_byte,
  output status_t     status,
  output logic [31:0] digest_word,
  output logic [2:0]  word_number,
  output logic        last_word
);

  logic [31:0] h [5];
  logic [31:0] a, b, c, d, e;
  logic [31:0] w [16];
  logic [5:0]  fill;
  logic [63:0] len;
  logic [6:0]  round_cnt;
  logic [2:0]  word_cnt;

  logic [7:0]  byte_in;
  logic [31:0] f_val, k_val, a_next, w_new;

  // Byte that enters the block.
  always_comb begin
    case (cmd.byte_sel)
      SEL_MSG:  byte_in = msg_byte;
      SEL_MARK: byte_in = PAD_MARK;
      SEL_ZERO: byte_in = 8'h00;
      SEL_LEN:  byte_in = len[63:56];
      default:  byte_in = 8'h00;
    endcase
  end

  // Round function and constant for the current round.
  always_comb begin
    if (round_cnt < ROUND_GRP_1) begin
      f_val = (b & c) | (~b & d);
      k_val = K_0;
    end else if (round_cnt < ROUND_GRP_2) begin
      f_val = b ^ c ^ d;
      k_val = K_1;
    end else if (round_cnt < ROUND_GRP_3) begin
      f_val = (b & c) | (b & d) | (c & d);
      k_val = K_2;
    end else begin
      f_val = b ^ c ^ d;
      k_val = K_3;
    end
    a_next = rotl(a, 5'd5) + f_val + e + k_val + w[0];
    w_new  = rotl(w[13] ^ w[8] ^ w[2] ^ w[0], 5'd1);
  end

  // Message window: bytes shift in during loading, words shift out during rounds.
  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      for (int i = 0; i < 15; i++) begin
        w[i] <= {w[i][23:0], w[i+1][31:24]};
      end
      w[15] <= {w[15][23:0], byte_in};
    end else if (cmd.round) begin
      for (int i = 0; i < 15; i++) begin
        w[i] <= w[i+1];
      end
      w[15] <= w_new;
    end
  end

  // Working variables; loaded from the chaining words when the last byte of the block shifts in.
  always_ff @(posedge clk) begin
    if (cmd.shift && fill == FILL_LAST) begin
      a <= h[0];
      b <= h[1];
      c <= h[2];
      d <= h[3];
      e <= h[4];
    end else if (cmd.round) begin
      a <= a_next;
      b <= a;
      c <= rotl(b, 5'd30);
      d <= c;
      e <= d;
    end
  end

  // Control-side counters and chaining words.
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      h        <= H_INIT;
      fill     <= '0;
      len      <= '0;
      round_cnt <= '0;
      word_cnt <= '0;
    end else begin
      if (cmd.shift) begin
        fill <= fill + 6'd1;
        if (fill == FILL_LAST) begin
          round_cnt <= '0;
        end
      end
      if (cmd.count_len) begin
        len <= len + 64'd8;
      end else if (cmd.shift && cmd.byte_sel == SEL_LEN) begin
        len <= {len[55:0], len[63:56]};
      end
      if (cmd.round) begin
        round_cnt <= round_cnt + 7'd1;
      end
      if (cmd.update) begin
        h[0] <= h[0] + a;
        h[1] <= h[1] + b;
        h[2] <= h[2] + c;
        h[3] <= h[3] + d;
        h[4] <= h[4] + e;
      end
      if (cmd.out_step) begin
        word_cnt <= word_cnt + 3'd1;
      end
    end
  end

  // Digest word selection.
  always_comb begin
    case (word_cnt)
      3'd0:    digest_word = h[0];
      3'd1:    digest_word = h[1];
      3'd2:    digest_word = h[2];
      3'd3:    digest_word = h[3];
      default: digest_word = h[4];
    endcase
  end

  assign word_number        = word_cnt;
  assign last_word          = (word_cnt == WORD_LAST);
  assign status.fill_full   = (fill == FILL_LAST);
  assign status.fill_at_len = (fill == FILL_LEN);
  assign status.round_done  = (round_cnt == ROUND_LAST);
  assign status.word_last   = (word_cnt == WORD_LAST);

endmodule

FILE: src/sha1_checker.sv
module sha1_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        end_of_message,
  input logic        done,
  input logic [2:0]  word_number,
  input logic        last_word
);

  // Digest words appear only while the engine is busy.
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("digest word shown while idle");

  // The final word is word four.
  a_last_num: assert property (@(posedge clk) disable iff (rst)
    done && last_word |-> word_number == 3'd4)
    else $error("last word has wrong position");

  // Words follow one another on consecutive cycles.
  a_word_seq: assert property (@(posedge clk) disable iff (rst)
    done && !last_word |=> done && word_number == $past(word_number) + 3'd1)
    else $error("digest words not consecutive");

  // An item that does not end the message gives no result next cycle.
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    start && !busy && !end_of_message |=> !done)
    else $error("result after an item that does not end the message");

  // The engine is free again after the last word.
  a_free_after: assert property (@(posedge clk) disable iff (rst)
    done && last_word |=> !busy)
    else $error("engine still busy after digest");

endmodule

bind sha1_hash_top sha1_checker u_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .end_of_message (end_of_message),
  .done           (done),
  .word_number    (word_number),
  .last_word      (last_word)
);

FILE: dv/sha1_hash_top_test.sv
module sha1_hash_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 330;
  localparam int STALL_LIMIT  = 3000;
  localparam int TAIL_CYCLES  = 300;

  localparam logic [31:0] CHAIN_INIT [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };
  localparam logic [31:0] ROUND_K [4] = '{
    32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
  };
  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam int BLOCK_BYTES = 64;
  localparam int LEN_OFFSET  = 56;

  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       fin;
  } msg_item_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [7:0]  msg_byte = '0;
  logic        has_byte = 1'b0;
  logic        end_of_message = 1'b0;
  logic        done;
  logic [31:0] digest_word;
  logic [2:0]  word_number;
  logic        last_word;

  // Items waiting to be sent, and digest words predicted but not yet seen.
  msg_item_t    pending_items [$];
  digest_word_t digest_due [$];

  // Shadow of the hash engine's state.
  logic [31:0] chain [5];
  logic [7:0]  block_buf [BLOCK_BYTES];
  int          block_fill;
  logic [63:0] message_bits;

  int items_total;
  int items_sent;
  int words_checked;
  int mismatches;
  int messages;
  int two_block_pads;
  int longest_msg;
  int burst_left;
  int gap_left;
  int stall_cycles;

  sha1_hash_top DUT (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .msg_byte       (msg_byte),
    .has_byte       (has_byte),
    .end_of_message (end_of_message),
    .done           (done),
    .digest_word    (digest_word),
    .word_number    (word_number),
    .last_word      (last_word)
  );

  always #1 clk = ~clk;

  function automatic logic [31:0] rol32(logic [31:0] v, int s);
    return (v << s) | (v >> (32 - s));
  endfunction

  // Return the predictor to the start of a fresh message.
  function automatic void clear_hash_state();
    for (int i = 0; i < 5; i++) chain[i] = CHAIN_INIT[i];
    for (int i = 0; i < BLOCK_BYTES; i++) block_buf[i] = '0;
    block_fill = 0;
    message_bits = '0;
  endfunction

  // One 80-round compression of the current block into the chaining words.
  function automatic void compress_block();
    logic [31:0] sched [80];
    logic [31:0] a, b, c, d, e, fn, nxt;
    for (int r = 0; r < 16; r++)
      sched[r] = {block_buf[4*r], block_buf[4*r+1], block_buf[4*r+2], block_buf[4*r+3]};
    for (int r = 16; r < 80; r++)
      sched[r] = rol32(sched[r-3] ^ sched[r-8] ^ sched[r-14] ^ sched[r-16], 1);
    a = chain[0];
    b = chain[1];
    c = chain[2];
    d = chain[3];
    e = chain[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 20) fn = (b & c) | (~b & d);
      else if (r < 40) fn = b ^ c ^ d;
      else if (r < 60) fn = (b & c) | (b & d) | (c & d);
      else fn = b ^ c ^ d;
      nxt = rol32(a, 5) + fn + e + ROUND_K[r / 20] + sched[r];
      e = d;
      d = c;
      c = rol32(b, 30);
      b = a;
      a = nxt;
    end
    chain[0] += a;
    chain[1] += b;
    chain[2] += c;
    chain[3] += d;
    chain[4] += e;
  endfunction

  // Apply one accepted item and queue the digest words that it produces.
  function automatic void absorb_item(msg_item_t it);
    int pos;
    digest_word_t dw;
    if (it.has) begin
      block_buf[block_fill] = it.data;
      block_fill++;
      message_bits += 64'd8;
      if (block_fill == BLOCK_BYTES) begin
        compress_block();
        block_fill = 0;
      end
    end
    if (!it.fin) return;
    // Padding: marker byte, zeros, then the big-endian bit length.
    pos = block_fill;
    block_buf[pos] = PAD_BYTE;
    for (int i = pos + 1; i < BLOCK_BYTES; i++) block_buf[i] = '0;
    if (pos >= LEN_OFFSET) begin
      compress_block();
      for (int i = 0; i < BLOCK_BYTES; i++) block_buf[i] = '0;
    end
    for (int k = 0; k < 8; k++) block_buf[LEN_OFFSET + k] = message_bits[63 - 8*k -: 8];
    compress_block();
    for (int k = 0; k < 5; k++) begin
      dw.word  = chain[k];
      dw.index = 3'(k);
      dw.last  = (k == 4);
      digest_due.push_back(dw);
    end
    clear_hash_state();
  endfunction

  function automatic void push_item(logic [7:0] data, logic has, logic fin);
    msg_item_t it;
    it.data = data;
    it.has  = has;
    it.fin  = fin;
    pending_items.push_back(it);
    items_total++;
  endfunction

  // Queue one whole message of random bytes with idle items scattered in it.
  // The message ends either on its last byte or on a separate empty item.
  function automatic int queue_message(int len, int idle_pct);
    int sent;
    bit end_on_byte;
    sent = 0;
    end_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < idle_pct) begin
        push_item(8'($urandom), 1'b0, 1'b0);
        sent++;
      end
      push_item(8'($urandom), 1'b1, end_on_byte && (i == len - 1));
      sent++;
    end
    if (!end_on_byte) begin
      push_item(8'($urandom), 1'b0, 1'b1);
      sent++;
    end
    messages++;
    if (len % BLOCK_BYTES >= LEN_OFFSET) two_block_pads++;
    if (len > longest_msg) longest_msg = len;
    return sent;
  endfunction

  // Driver: sends items in bursts of random length separated by random gaps.
  always @(posedge clk) begin
    msg_item_t it;
    if (rst) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (start) begin
        it.data = msg_byte;
        it.has  = has_byte;
        it.fin  = end_of_message;
        absorb_item(it);
        items_sent++;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_items.size() > 0) begin
        it = pending_items.pop_front();
        start <= 1'b1;
        msg_byte <= it.data;
        has_byte <= it.has;
        end_of_message <= it.fin;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every strobed word is checked against the oldest prediction.
  always @(posedge clk) begin
    digest_word_t dw;
    if (!rst && done === 1'b1) begin
      if (digest_due.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: unexpected digest word %h (number %0d, last %b)",
                   $realtime, digest_word, word_number, last_word);
        mismatches++;
      end else begin
        dw = digest_due.pop_front();
        words_checked++;
        if (digest_word !== dw.word || word_number !== dw.index || last_word !== dw.last) begin
          if (mismatches < 10)
            $display("%0t: digest word mismatch: expected %h/%0d/%b, got %h/%0d/%b",
                     $realtime, dw.word, dw.index, dw.last,
                     digest_word, word_number, last_word);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: gives up when neither an item nor a result moves for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done === 1'b1) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Timeout: no item accepted and no digest word seen for %0d cycles",
               STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int random_items;
    int len;
    int pick;
    clear_hash_state();
    items_total = 0;
    items_sent = 0;
    words_checked = 0;
    mismatches = 0;
    messages = 0;
    two_block_pads = 0;
    longest_msg = 0;
    burst_left = $urandom_range(1, 40);
    gap_left = 0;
    stall_cycles = 0;

    // Directed: empty message, with a junk byte that must be ignored.
    push_item(8'hFF, 1'b0, 1'b1);
    // An idle item on its own changes nothing.
    push_item(8'hAA, 1'b0, 1'b0);
    // "abc", ending on the last byte.
    push_item(8'h61, 1'b1, 1'b0);
    push_item(8'h62, 1'b1, 1'b0);
    push_item(8'h63, 1'b1, 1'b1);
    // Single-byte messages at both extremes of the byte.
    push_item(8'h00, 1'b1, 1'b1);
    push_item(8'hFF, 1'b1, 1'b1);
    // Two bytes closed by a separate empty item.
    push_item(8'hFF, 1'b1, 1'b0);
    push_item(8'h00, 1'b1, 1'b0);
    push_item(8'h55, 1'b0, 1'b1);
    // Bytes with idle items between them.
    push_item(8'h5A, 1'b1, 1'b0);
    push_item(8'h00, 1'b0, 1'b0);
    push_item(8'hFF, 1'b0, 1'b0);
    push_item(8'hA5, 1'b1, 1'b0);
    push_item(8'h00, 1'b0, 1'b1);
    // Empty message straight after another one.
    push_item(8'h00, 1'b0, 1'b1);
    messages = 7;
    longest_msg = 3;

    // Random messages: mostly short, some around the padding and block
    // boundaries, a few around the end of the second block.
    random_items = items_total;
    while (random_items < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) len = $urandom_range(0, 20);
      else if (pick < 93) len = $urandom_range(53, 66);
      else len = $urandom_range(116, 130);
      random_items += queue_message(len, $urandom_range(0, 15));
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (items_sent < items_total || digest_due.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Hashed %0d messages from %0d items (longest %0d bytes, %0d padded over two blocks).",
             messages, items_total, longest_msg, two_block_pads);
    $display("Checked %0d digest words, %0d mismatched.", words_checked, mismatches);
    if (mismatches == 0 && digest_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: files.f
src/sha1_pkg.sv
src/sha1_ctrl.sv
src/sha1_dpath.sv
src/sha1_hash_top.sv
src/sha1_checker.sv
dv/sha1_hash_top_test.sv
